### rtl/core/rlpenc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpenc_pkg
// Shared types and constants for the RLP item encoder: operation codes,
// prefix bases and the encoded-item bundle passed to the byte shifter.
// ----------------------------------------------------------------------------
package rlpenc_pkg;

    typedef enum logic [1:0] {
        OP_STRING  = 2'd0,
        OP_LIST    = 2'd1,
        OP_PAYLOAD = 2'd2,
        OP_INTEGER = 2'd3
    } t_op;

    localparam int MAX_LEN_OCTETS_DEF = 4;
    localparam int LEN_W         = 32;
    localparam int INT_W         = 64;
    localparam int INT_BYTES     = INT_W / 8;
    localparam int MAX_BYTES     = INT_BYTES + 1;
    localparam int CNT_W         = $clog2(MAX_BYTES + 1);

    localparam logic [7:0] SINGLE_MAX   = 8'h7f;
    localparam logic [7:0] SHORT_MAX    = 8'd55;
    localparam logic [7:0] STR_SHORT    = 8'h80;
    localparam logic [7:0] STR_LONG     = 8'hb7;
    localparam logic [7:0] LIST_SHORT   = 8'hc0;
    localparam logic [7:0] LIST_LONG    = 8'hf7;

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } t_enc;

endpackage

### rtl/core/rlpenc_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpenc_encode
// Combinational RLP encoder: turns one registered item into up to nine
// output bytes, first byte at index 0, plus the byte count.
// ----------------------------------------------------------------------------
module rlpenc_encode #(
    parameter int MAX_LEN_OCTETS = rlpenc_pkg::MAX_LEN_OCTETS_DEF
) (
    input  rlpenc_pkg::t_op              i_op,
    input  logic [rlpenc_pkg::LEN_W-1:0] i_len,
    input  logic [7:0]                   i_data_byte,
    input  logic [rlpenc_pkg::INT_W-1:0] i_int_value,
    output rlpenc_pkg::t_enc             o_enc
);

    localparam logic [rlpenc_pkg::LEN_W-1:0] LenLimit = (MAX_LEN_OCTETS >= 4) ?
        {rlpenc_pkg::LEN_W{1'b1}} :
        rlpenc_pkg::LEN_W'((64'd1 << (8 * MAX_LEN_OCTETS)) - 64'd1);

    logic [rlpenc_pkg::LEN_W-1:0]     sat_len;
    logic [rlpenc_pkg::INT_W-1:0]     sel_val;
    logic [rlpenc_pkg::INT_W-1:0]     aligned;
    logic [rlpenc_pkg::CNT_W-1:0]     nb;
    logic [7:0]                       short_base;
    logic [7:0]                       long_base;

    always_comb begin
        sat_len = (i_len > LenLimit) ? LenLimit : i_len;
        sel_val = (i_op == rlpenc_pkg::OP_INTEGER) ? i_int_value :
                  {{(rlpenc_pkg::INT_W - rlpenc_pkg::LEN_W){1'b0}}, sat_len};
        // minimal big-endian byte count: highest nonzero byte wins
        nb = '0;
        for (int i = 0; i < rlpenc_pkg::INT_BYTES; i++) begin
            if (sel_val[8*i +: 8] != 8'd0) begin
                nb = rlpenc_pkg::CNT_W'(i + 1);
            end
        end
        // left-align so the most significant used byte sits at the top
        aligned = sel_val << {rlpenc_pkg::CNT_W'(rlpenc_pkg::INT_BYTES) - nb, 3'b000};
    end

    always_comb begin
        short_base = (i_op == rlpenc_pkg::OP_LIST) ? rlpenc_pkg::LIST_SHORT :
                                                     rlpenc_pkg::STR_SHORT;
        long_base  = (i_op == rlpenc_pkg::OP_LIST) ? rlpenc_pkg::LIST_LONG :
                                                     rlpenc_pkg::STR_LONG;
        o_enc = '0;
        for (int k = 1; k < rlpenc_pkg::MAX_BYTES; k++) begin
            o_enc.bytes[k] = aligned[rlpenc_pkg::INT_W - 1 - 8*(k-1) -: 8];
        end
        case (i_op)
            rlpenc_pkg::OP_STRING, rlpenc_pkg::OP_LIST: begin
                if (i_op == rlpenc_pkg::OP_STRING && i_len == 32'd1 &&
                    i_data_byte <= rlpenc_pkg::SINGLE_MAX) begin
                    // a single small byte encodes itself: no prefix
                    o_enc.count = '0;
                end else if (sat_len <= 32'(rlpenc_pkg::SHORT_MAX)) begin
                    o_enc.bytes[0] = short_base + sat_len[7:0];
                    o_enc.count    = rlpenc_pkg::CNT_W'(1);
                end else begin
                    o_enc.bytes[0] = long_base + 8'(nb);
                    o_enc.count    = nb + rlpenc_pkg::CNT_W'(1);
                end
            end
            rlpenc_pkg::OP_PAYLOAD: begin
                o_enc.bytes[0] = i_data_byte;
                o_enc.count    = rlpenc_pkg::CNT_W'(1);
            end
            rlpenc_pkg::OP_INTEGER: begin
                if (i_int_value == '0) begin
                    o_enc.bytes[0] = rlpenc_pkg::STR_SHORT;
                    o_enc.count    = rlpenc_pkg::CNT_W'(1);
                end else if (i_int_value <= 64'(rlpenc_pkg::SINGLE_MAX)) begin
                    o_enc.bytes[0] = i_int_value[7:0];
                    o_enc.count    = rlpenc_pkg::CNT_W'(1);
                end else begin
                    o_enc.bytes[0] = rlpenc_pkg::STR_SHORT + 8'(nb);
                    o_enc.count    = nb + rlpenc_pkg::CNT_W'(1);
                end
            end
            default: begin
                o_enc.count = '0;
            end
        endcase
    end

endmodule

### rtl/core/rlpenc_shifter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpenc_shifter
// Result register: holds the encoded bytes of one item and presents them
// one per cycle, marking the final byte of each item.
// ----------------------------------------------------------------------------
module rlpenc_shifter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rlpenc_pkg::t_enc i_enc,
    output logic             o_take,
    output logic             o_valid,
    output logic [7:0]       o_byte,
    output logic             o_last
);

    logic [rlpenc_pkg::MAX_BYTES-1:0][7:0] r_buf;
    logic [rlpenc_pkg::MAX_BYTES-1:0][7:0] n_buf;
    logic [rlpenc_pkg::CNT_W-1:0]          r_cnt;
    logic [rlpenc_pkg::CNT_W-1:0]          n_cnt;

    // free after this cycle when empty or on the last byte
    assign o_take  = (r_cnt <= rlpenc_pkg::CNT_W'(1));
    assign o_valid = (r_cnt != '0);
    assign o_last  = (r_cnt == rlpenc_pkg::CNT_W'(1));
    assign o_byte  = r_buf[0];

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (i_load) begin
            n_buf = i_enc.bytes;
            n_cnt = i_enc.count;
        end else if (r_cnt != '0) begin
            // advance to the next byte
            n_buf = r_buf >> 8;
            n_cnt = r_cnt - rlpenc_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

### rtl/core/rlp_item_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlp_item_encoder_core
// RLP item encoder: string/list headers, payload bytes and integers.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its bytes appear on
// o_out_byte after the item register and then the output shifter, one per
// cycle with o_valid high, the final byte flagged by o_last_of_run; the
// receiver cannot stall, so take every strobed byte. An item emits 0 to 9
// bytes; the next item is decoded while the last byte of the current one
// goes out, so payload bytes stream at one per cycle. busy rises only while
// a registered item waits for the output shifter to drain. A string header
// for one byte of 0x7f or less emits nothing and produces no last mark.
module rlp_item_encoder_core #(
    parameter int MAX_LEN_OCTETS = rlpenc_pkg::MAX_LEN_OCTETS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_operation,
    input  logic [rlpenc_pkg::LEN_W-1:0] i_length,
    input  logic [7:0]                   i_data_byte,
    input  logic [rlpenc_pkg::INT_W-1:0] i_int_value,
    output logic                         o_valid,
    output logic [7:0]                   o_out_byte,
    output logic                         o_last_of_run
);

    logic                         r_iv;
    rlpenc_pkg::t_op              r_op;
    logic [rlpenc_pkg::LEN_W-1:0] r_len;
    logic [7:0]                   r_db;
    logic [rlpenc_pkg::INT_W-1:0] r_int;
    logic                         accept;
    logic                         take;
    logic                         load;
    rlpenc_pkg::t_enc             enc;

    assign load   = r_iv && take;
    assign busy   = r_iv && !take;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= rlpenc_pkg::t_op'(i_operation);
            r_len <= i_length;
            r_db  <= i_data_byte;
            r_int <= i_int_value;
        end
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (accept) begin
            r_iv <= 1'b1;
        end else if (load) begin
            r_iv <= 1'b0;
        end
    end

    rlpenc_encode #(
        .MAX_LEN_OCTETS(MAX_LEN_OCTETS)
    ) u_encode (
        .i_op       (r_op),
        .i_len      (r_len),
        .i_data_byte(r_db),
        .i_int_value(r_int),
        .o_enc      (enc)
    );

    rlpenc_shifter u_shifter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (load),
        .i_enc  (enc),
        .o_take (take),
        .o_valid(o_valid),
        .o_byte (o_out_byte),
        .o_last (o_last_of_run)
    );

endmodule

### rtl/core/rlpenc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlpenc_checker
// Port-level checks for the RLP item encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rlpenc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_last_of_run
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("output or busy active right after reset");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_run |-> o_valid)
        else $error("last mark without a valid byte");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |=> o_valid)
        else $error("transaction output ended without a last mark");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && !busy))
        else $error("busy rose without an accepted transaction");

endmodule

bind rlp_item_encoder_core rlpenc_checker u_rlpenc_checker (.*);
